>>> sv/rpnlex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpnlex_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 3;
   localparam int MAX_LEN_DEF = 32;

   // Token kinds carried on the result channel.
   localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OPER   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd2;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sign(input logic [CHAR_W-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic logic is_immed_op(input logic [CHAR_W-1:0] c);
      return (c == CH_SLASH) || (c == CH_STAR);
   endfunction

endpackage

`default_nettype wire

>>> sv/rpn_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Latency: a word that finishes no token gives its result (if any) in the next cycle.
// A token streams out at one word per cycle while the output is not stalled, after the
// first store read in S_FLUSH_RD; no new item is taken until S_END or S_REDO is done.
// Throughput is set by the single read port of the symbol store during token readout.
// Reset (synchronous, active high) returns the scanner to idle with an empty token.

module rpn_token_lexer #(
   parameter int MAX_LEN = rpnlex_pkg::MAX_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_kind,
   input  wire logic [rpnlex_pkg::CHAR_W-1:0]   req_char_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [rpnlex_pkg::KIND_W-1:0]        rsp_token_kind,
   output logic [rpnlex_pkg::CHAR_W-1:0]        rsp_sym_char,
   output logic                                 rsp_last
);
   import rpnlex_pkg::*;

   // A token holds at most MAX_LEN-1 characters, so the store has that many entries.
   localparam int DEPTH = MAX_LEN - 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = $clog2(MAX_LEN);
   localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LEN - 1);
   localparam logic [LW-1:0] LEN_ONE  = LW'(1);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER
   } mode_type;

   typedef enum logic [2:0] {
      S_IN,        // waiting for an input word
      S_FLUSH_RD,  // first read of a pending token
      S_FLUSH,     // streaming the token, one character per word
      S_END,       // end token after a flush
      S_REDO       // terminator character handled again as if idle
   } state_type;

   state_type         state_ff;
   mode_type          mode_ff;
   logic [LW-1:0]     len_ff;
   logic [LW-1:0]     idx_ff;
   logic [CHAR_W-1:0] first_ff;
   logic [CHAR_W-1:0] hold_ff;
   logic [KIND_W-1:0] tok_kind_ff;
   logic              post_end_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_load;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              accept;
   logic              c_letter, c_digit, c_sign, c_op;
   logic              h_letter, h_digit, h_sign, h_op;
   logic              extends_tok;
   logic [KIND_W-1:0] flush_kind;
   logic              flush_last;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [CHAR_W-1:0] rd_data;

   // The output register is free when empty or when its word leaves this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IN) && out_free;
   assign accept    = req_valid && req_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_token_kind = rsp_kind_ff;
   assign rsp_sym_char   = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      c_letter = is_letter(req_char_in);
      c_digit  = is_digit(req_char_in);
      c_sign   = is_sign(req_char_in);
      c_op     = is_immed_op(req_char_in);
      h_letter = is_letter(hold_ff);
      h_digit  = is_digit(hold_ff);
      h_sign   = is_sign(hold_ff);
      h_op     = is_immed_op(hold_ff);
      extends_tok = ((mode_ff == MODE_IDENT) && c_letter) ||
                    ((mode_ff == MODE_NUMBER) && c_digit);
      // A lone sign is an operator; everything else in number mode is a number.
      if (mode_ff == MODE_IDENT) begin
         flush_kind = KIND_IDENT;
      end else if ((len_ff == LEN_ONE) && is_sign(first_ff)) begin
         flush_kind = KIND_OPER;
      end else begin
         flush_kind = KIND_NUMBER;
      end
      flush_last = (idx_ff == (len_ff - LEN_ONE));
   end

   // A new word enters the output register on exactly the branches of the state machine
   // that load one; otherwise the held word stays until it is taken.
   always_comb begin
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IN: begin
            if (accept) begin
               if (req_kind) begin
                  rsp_load = (mode_ff == MODE_IDLE);
               end else if (extends_tok) begin
                  rsp_load = (len_ff == LEN_FULL);
               end else begin
                  rsp_load = (mode_ff == MODE_IDLE) && c_op;
               end
            end
         end
         S_FLUSH, S_END: begin
            rsp_load = out_free;
         end
         S_REDO: begin
            rsp_load = out_free && h_op;
         end
         default: begin
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // Store writes happen only while taking input or restarting a token, and reads only
   // during readout, so the same entry is never written and read in one cycle.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = req_char_in;
      rd_en   = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         S_IN: begin
            if (accept && !req_kind) begin
               if (extends_tok) begin
                  wr_en   = (len_ff != LEN_FULL);
                  wr_addr = len_ff[AW-1:0];
               end else if (mode_ff == MODE_IDLE) begin
                  wr_en = c_letter || c_sign || c_digit;
               end
            end
         end
         S_FLUSH_RD: begin
            rd_en = 1'b1;
         end
         S_FLUSH: begin
            rd_en   = out_free && !flush_last;
            rd_addr = AW'(idx_ff + LEN_ONE);
         end
         S_REDO: begin
            wr_en   = out_free && (h_letter || h_sign || h_digit);
            wr_data = hold_ff;
         end
         default: begin
         end
      endcase
   end

   rpnlex_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IN;
         mode_ff      <= MODE_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IN: begin
               if (accept) begin
                  if (req_kind) begin
                     if (mode_ff != MODE_IDLE) begin
                        tok_kind_ff <= flush_kind;
                        post_end_ff <= 1'b1;
                        state_ff    <= S_FLUSH_RD;
                     end else begin
                        rsp_kind_ff  <= KIND_END;
                        rsp_char_ff  <= CH_NUL;
                        rsp_last_ff  <= 1'b1;
                     end
                  end else if (extends_tok) begin
                     if (len_ff == LEN_FULL) begin
                        // Overflow: one error word, token and character dropped.
                        rsp_kind_ff  <= KIND_ERROR;
                        rsp_char_ff  <= CH_NUL;
                        rsp_last_ff  <= 1'b1;
                        mode_ff      <= MODE_IDLE;
                        len_ff       <= '0;
                     end else begin
                        len_ff <= len_ff + LEN_ONE;
                     end
                  end else if (mode_ff != MODE_IDLE) begin
                     tok_kind_ff <= flush_kind;
                     post_end_ff <= 1'b0;
                     hold_ff     <= req_char_in;
                     state_ff    <= S_FLUSH_RD;
                  end else if (c_op) begin
                     rsp_kind_ff  <= KIND_OPER;
                     rsp_char_ff  <= req_char_in;
                     rsp_last_ff  <= 1'b1;
                  end else if (c_letter) begin
                     mode_ff  <= MODE_IDENT;
                     len_ff   <= LEN_ONE;
                     first_ff <= req_char_in;
                  end else if (c_sign || c_digit) begin
                     mode_ff  <= MODE_NUMBER;
                     len_ff   <= LEN_ONE;
                     first_ff <= req_char_in;
                  end
               end
            end
            S_FLUSH_RD: begin
               idx_ff   <= '0;
               state_ff <= S_FLUSH;
            end
            S_FLUSH: begin
               if (out_free) begin
                  rsp_kind_ff  <= tok_kind_ff;
                  rsp_char_ff  <= rd_data;
                  rsp_last_ff  <= flush_last;
                  if (flush_last) begin
                     mode_ff  <= MODE_IDLE;
                     len_ff   <= '0;
                     state_ff <= post_end_ff ? S_END : S_REDO;
                  end else begin
                     idx_ff <= idx_ff + LEN_ONE;
                  end
               end
            end
            S_END: begin
               if (out_free) begin
                  rsp_kind_ff  <= KIND_END;
                  rsp_char_ff  <= CH_NUL;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IN;
               end
            end
            S_REDO: begin
               if (out_free) begin
                  if (h_op) begin
                     rsp_kind_ff  <= KIND_OPER;
                     rsp_char_ff  <= hold_ff;
                     rsp_last_ff  <= 1'b1;
                  end else if (h_letter) begin
                     mode_ff  <= MODE_IDENT;
                     len_ff   <= LEN_ONE;
                     first_ff <= hold_ff;
                  end else if (h_sign || h_digit) begin
                     mode_ff  <= MODE_NUMBER;
                     len_ff   <= LEN_ONE;
                     first_ff <= hold_ff;
                  end
                  state_ff <= S_IN;
               end
            end
            default: begin
               state_ff <= S_IN;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/rpnlex_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Symbol store: one write port and one read port with registered read data.
module rpnlex_store #(
   parameter int DEPTH = 31,
   parameter int AW    = 5
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [rpnlex_pkg::CHAR_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic [rpnlex_pkg::CHAR_W-1:0]   rd_data_ff
);
   import rpnlex_pkg::*;

   logic [CHAR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
